>>> rtl/xie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xie_pkg
// shared types and constants of the x86 instruction byte encoder
// ----------------------------------------------------------------------------
package xie_pkg;

    localparam int MAX_BYTES   = 11;
    localparam int LEN_W       = $clog2(MAX_BYTES + 1);
    localparam int IDX_W       = $clog2(MAX_BYTES);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register numbers with special encodings: esp and ebp in memory operands, eax in cmp
    localparam logic [2:0] REG_EAX = 3'd0;
    localparam logic [2:0] REG_ESP = 3'd4;
    localparam logic [2:0] REG_EBP = 3'd5;

    // instruction form selectors
    localparam logic [5:0] CMD_MOV_RR       = 6'd0;
    localparam logic [5:0] CMD_MOV_RI       = 6'd1;
    localparam logic [5:0] CMD_MOV_AR       = 6'd2;
    localparam logic [5:0] CMD_MOV_AI       = 6'd3;
    localparam logic [5:0] CMD_MOV_MR       = 6'd4;
    localparam logic [5:0] CMD_MOV_MI       = 6'd5;
    localparam logic [5:0] CMD_MOV_RM       = 6'd6;
    localparam logic [5:0] CMD_MOV_RA       = 6'd7;
    localparam logic [5:0] CMD_PUSH_R       = 6'd8;
    localparam logic [5:0] CMD_PUSH_I       = 6'd9;
    localparam logic [5:0] CMD_PUSH_M       = 6'd10;
    localparam logic [5:0] CMD_PUSH_A       = 6'd11;
    localparam logic [5:0] CMD_POP_R        = 6'd12;
    localparam logic [5:0] CMD_POP_A        = 6'd13;
    localparam logic [5:0] CMD_JMP_R        = 6'd14;
    localparam logic [5:0] CMD_JMP_REL      = 6'd15;
    localparam logic [5:0] CMD_JMP_M        = 6'd16;
    localparam logic [5:0] CMD_JMP_A        = 6'd17;
    localparam logic [5:0] CMD_JZ_REL       = 6'd18;
    localparam logic [5:0] CMD_JNZ_REL      = 6'd19;
    localparam logic [5:0] CMD_ADD_RR       = 6'd20;
    localparam logic [5:0] CMD_ADD_RI       = 6'd21;
    localparam logic [5:0] CMD_ADD_RM       = 6'd22;
    localparam logic [5:0] CMD_ADD_RA       = 6'd23;
    localparam logic [5:0] CMD_SUB_RR       = 6'd24;
    localparam logic [5:0] CMD_SUB_RI       = 6'd25;
    localparam logic [5:0] CMD_SUB_RM       = 6'd26;
    localparam logic [5:0] CMD_SUB_RA       = 6'd27;
    localparam logic [5:0] CMD_XOR_RR       = 6'd28;
    localparam logic [5:0] CMD_TEST_RR      = 6'd29;
    localparam logic [5:0] CMD_TEST_RI      = 6'd30;
    localparam logic [5:0] CMD_CALL_R       = 6'd31;
    localparam logic [5:0] CMD_CALL_REL     = 6'd32;
    localparam logic [5:0] CMD_CALL_M       = 6'd33;
    localparam logic [5:0] CMD_CALL_A       = 6'd34;
    localparam logic [5:0] CMD_NOP          = 6'd35;
    localparam logic [5:0] CMD_RET          = 6'd36;
    localparam logic [5:0] CMD_PUSHAD       = 6'd37;
    localparam logic [5:0] CMD_POPAD        = 6'd38;
    localparam logic [5:0] CMD_REP_MOVSB    = 6'd39;
    localparam logic [5:0] CMD_REP_MOVSW    = 6'd40;
    localparam logic [5:0] CMD_REP_MOVSD    = 6'd41;
    localparam logic [5:0] CMD_CMP_RR32     = 6'd42;
    localparam logic [5:0] CMD_CMP_RR16     = 6'd43;
    localparam logic [5:0] CMD_CMP_RR8      = 6'd44;
    localparam logic [5:0] CMD_CMP_RI32     = 6'd45;
    localparam logic [5:0] CMD_CMP_RI16     = 6'd46;
    localparam logic [5:0] CMD_CMP_RI8      = 6'd47;

    typedef struct packed {
        logic [5:0]         cmd;
        logic [2:0]         reg_a;
        logic [2:0]         reg_b;
        logic signed [31:0] offset;
        logic [31:0]        immediate;
        logic [31:0]        address;
    } xie_in_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } xie_out_t;

    // one fully classified instruction: bytes in emission order and count
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
    } xie_plan_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic      valid;
        xie_plan_t plan;
    } xie_head_t;

endpackage

>>> rtl/xie_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xie_front
// classifies one request into its complete byte sequence and length
// ----------------------------------------------------------------------------
module xie_front
    import xie_pkg::*;
(
    input  xie_in_t   instr,
    output xie_plan_t plan
);

    function automatic xie_plan_t put8(xie_plan_t p, logic [7:0] v);
        if (p.len < LEN_W'(MAX_BYTES))
        begin
            p.bytes[p.len[IDX_W-1:0]] = v;
            p.len = p.len + LEN_W'(1);
        end
        return p;
    endfunction

    function automatic xie_plan_t put16(xie_plan_t p, logic [15:0] v);
        p = put8(p, v[7:0]);
        p = put8(p, v[15:8]);
        return p;
    endfunction

    function automatic xie_plan_t put32(xie_plan_t p, logic [31:0] v);
        p = put16(p, v[15:0]);
        p = put16(p, v[31:16]);
        return p;
    endfunction

    function automatic logic [7:0] rr(logic [2:0] r, logic [2:0] m);
        return {2'b11, r, m};
    endfunction

    // [base+off]: short form without displacement unless ebp or nonzero offset
    function automatic xie_plan_t mem_base(xie_plan_t p, logic [2:0] regf,
                                           logic [2:0] base, logic [31:0] off);
        if (off != 32'd0 || base == REG_EBP)
        begin
            p = put8(p, {2'b10, regf, base});
            if (base == REG_ESP)
            begin
                p = put8(p, 8'h24);
            end
            p = put32(p, off);
        end
        else
        begin
            p = put8(p, {2'b00, regf, base});
            if (base == REG_ESP)
            begin
                p = put8(p, 8'h24);
            end
        end
        return p;
    endfunction

    function automatic xie_plan_t mem_abs(xie_plan_t p, logic [2:0] regf,
                                          logic [31:0] addr);
        p = put8(p, {2'b00, regf, 3'b101});
        p = put32(p, addr);
        return p;
    endfunction

    logic [2:0]  a;
    logic [2:0]  b;
    logic [31:0] off;
    logic [31:0] imm;
    logic [31:0] addr;
    logic [31:0] ea;
    logic [31:0] rel5;
    logic [31:0] rel6;

    assign a    = instr.reg_a;
    assign b    = instr.reg_b;
    assign off  = instr.offset;
    assign imm  = instr.immediate;
    assign addr = instr.address;
    assign ea   = addr + off;
    assign rel5 = addr - 32'd5;
    assign rel6 = addr - 32'd6;

    always_comb
    begin
        xie_plan_t p;
        p.bytes = '0;
        p.len   = '0;
        unique case (instr.cmd)
            CMD_MOV_RR:    begin p = put8(p, 8'h8B); p = put8(p, rr(a, b)); end
            CMD_MOV_RI:    begin p = put8(p, 8'hB8 + {5'd0, a}); p = put32(p, imm); end
            CMD_MOV_AR:    begin p = put8(p, 8'h89); p = mem_abs(p, b, addr); end
            CMD_MOV_AI:
            begin
                p = put8(p, 8'hC7);
                p = mem_abs(p, 3'd0, addr);
                p = put32(p, imm);
            end
            CMD_MOV_MR:    begin p = put8(p, 8'h89); p = mem_base(p, b, a, off); end
            CMD_MOV_MI:
            begin
                p = put8(p, 8'hC7);
                p = mem_base(p, 3'd0, a, off);
                p = put32(p, imm);
            end
            CMD_MOV_RM:    begin p = put8(p, 8'h8B); p = mem_base(p, a, b, off); end
            CMD_MOV_RA:    begin p = put8(p, 8'h8B); p = mem_abs(p, a, ea); end
            CMD_PUSH_R:    p = put8(p, 8'h50 + {5'd0, a});
            CMD_PUSH_I:    begin p = put8(p, 8'h68); p = put32(p, imm); end
            CMD_PUSH_M:    begin p = put8(p, 8'hFF); p = mem_base(p, 3'd6, a, off); end
            CMD_PUSH_A:    begin p = put8(p, 8'hFF); p = mem_abs(p, 3'd6, ea); end
            CMD_POP_R:     p = put8(p, 8'h58 + {5'd0, a});
            CMD_POP_A:     begin p = put8(p, 8'h8F); p = mem_abs(p, 3'd0, addr); end
            CMD_JMP_R:     begin p = put8(p, 8'hFF); p = put8(p, rr(3'd4, a)); end
            CMD_JMP_REL:   begin p = put8(p, 8'hE9); p = put32(p, rel5); end
            CMD_JMP_M:     begin p = put8(p, 8'hFF); p = mem_base(p, 3'd4, a, off); end
            CMD_JMP_A:     begin p = put8(p, 8'hFF); p = mem_abs(p, 3'd4, ea); end
            CMD_JZ_REL:
            begin
                p = put8(p, 8'h0F);
                p = put8(p, 8'h84);
                p = put32(p, rel6);
            end
            CMD_JNZ_REL:
            begin
                p = put8(p, 8'h0F);
                p = put8(p, 8'h85);
                p = put32(p, rel6);
            end
            CMD_ADD_RR:    begin p = put8(p, 8'h03); p = put8(p, rr(a, b)); end
            CMD_ADD_RI:
            begin
                p = put8(p, 8'h81);
                p = put8(p, rr(3'd0, a));
                p = put32(p, imm);
            end
            CMD_ADD_RM:    begin p = put8(p, 8'h03); p = mem_base(p, a, b, off); end
            CMD_ADD_RA:    begin p = put8(p, 8'h03); p = mem_abs(p, a, ea); end
            CMD_SUB_RR:    begin p = put8(p, 8'h2B); p = put8(p, rr(a, b)); end
            CMD_SUB_RI:
            begin
                p = put8(p, 8'h81);
                p = put8(p, rr(3'd5, a));
                p = put32(p, imm);
            end
            CMD_SUB_RM:    begin p = put8(p, 8'h2B); p = mem_base(p, a, b, off); end
            CMD_SUB_RA:    begin p = put8(p, 8'h2B); p = mem_abs(p, a, ea); end
            CMD_XOR_RR:    begin p = put8(p, 8'h33); p = put8(p, rr(a, b)); end
            CMD_TEST_RR:   begin p = put8(p, 8'h85); p = put8(p, rr(b, a)); end
            CMD_TEST_RI:
            begin
                p = put8(p, 8'hF7);
                p = put8(p, rr(3'd0, a));
                p = put32(p, imm);
            end
            CMD_CALL_R:    begin p = put8(p, 8'hFF); p = put8(p, rr(3'd2, a)); end
            CMD_CALL_REL:  begin p = put8(p, 8'hE8); p = put32(p, rel5); end
            CMD_CALL_M:    begin p = put8(p, 8'hFF); p = mem_base(p, 3'd2, a, off); end
            CMD_CALL_A:    begin p = put8(p, 8'hFF); p = mem_abs(p, 3'd2, ea); end
            CMD_NOP:       p = put8(p, 8'h90);
            CMD_RET:
            begin
                // plain ret when the pop count is zero
                if (imm[15:0] != 16'd0)
                begin
                    p = put8(p, 8'hC2);
                    p = put16(p, imm[15:0]);
                end
                else
                begin
                    p = put8(p, 8'hC3);
                end
            end
            CMD_PUSHAD:    p = put8(p, 8'h60);
            CMD_POPAD:     p = put8(p, 8'h61);
            CMD_REP_MOVSB: begin p = put8(p, 8'hF3); p = put8(p, 8'hA4); end
            CMD_REP_MOVSW:
            begin
                p = put8(p, 8'h66);
                p = put8(p, 8'hF3);
                p = put8(p, 8'hA5);
            end
            CMD_REP_MOVSD: begin p = put8(p, 8'hF3); p = put8(p, 8'hA5); end
            CMD_CMP_RR32:  begin p = put8(p, 8'h3B); p = put8(p, rr(b, a)); end
            CMD_CMP_RR16:
            begin
                p = put8(p, 8'h66);
                p = put8(p, 8'h3B);
                p = put8(p, rr(b, a));
            end
            CMD_CMP_RR8:   begin p = put8(p, 8'h3A); p = put8(p, rr(b, a)); end
            CMD_CMP_RI32:
            begin
                // eax has its own short opcode
                if (a == REG_EAX)
                begin
                    p = put8(p, 8'h3D);
                    p = put32(p, imm);
                end
                else
                begin
                    p = put8(p, 8'h81);
                    p = put8(p, rr(3'd7, a));
                    p = put32(p, imm);
                end
            end
            CMD_CMP_RI16:
            begin
                p = put8(p, 8'h66);
                p = put8(p, 8'h81);
                p = put8(p, rr(3'd7, a));
                p = put16(p, imm[15:0]);
            end
            CMD_CMP_RI8:
            begin
                p = put8(p, 8'h80);
                p = put8(p, rr(3'd7, a));
                p = put8(p, imm[7:0]);
            end
            default:       p.len = '0;
        endcase
        plan = p;
    end

endmodule

>>> rtl/xie_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xie_queue
// short fifo of classified instructions between front and back end
// ----------------------------------------------------------------------------
module xie_queue
    import xie_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  xie_plan_t wr_plan,
    output logic      full,
    input  logic      rd_en,
    output xie_head_t head
);

    xie_plan_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_wr;
    logic              do_rd;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.plan  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_plan;
        end
    end

endmodule

>>> rtl/xie_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xie_back
// serializes the queue head into byte words behind an output register
// ----------------------------------------------------------------------------
module xie_back
    import xie_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  xie_head_t head,
    output logic      take,
    output logic      empty,
    input  logic      pop,
    output xie_out_t  code
);

    logic             out_valid_reg;
    logic             out_valid_next;
    xie_out_t         out_word_reg;
    xie_out_t         out_word_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             advance;
    logic             at_last;

    assign advance = !out_valid_reg || pop;
    assign at_last = (LEN_W'(idx_reg) == head.plan.len - LEN_W'(1));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        idx_next       = idx_reg;
        take           = 1'b0;
        if (advance)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                out_word_next.code_byte = head.plan.bytes[idx_reg];
                out_word_next.last_byte = at_last;
                if (at_last)
                begin
                    idx_next = '0;
                    take     = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign empty = !out_valid_reg;
    assign code  = out_word_reg;

endmodule

>>> rtl/x86_instruction_byte_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_instruction_byte_encoder
// encodes 32-bit x86 instruction requests into machine code, one byte a word
// ----------------------------------------------------------------------------
// each request pushed into instr comes out as its machine code, one byte per
// word on code, little-endian for multi-byte fields, with last_byte set on the
// final byte. an instruction puts as many words on the output as it has
// bytes (1 to 11); the byte-wide output register of the back end moves one
// byte per cycle while pop is held. the first byte of a request is written
// into a queue entry, then into the output register, before it is on code.
// the front end classifies a request in the cycle it is pushed and takes one
// request per cycle as long as the four-entry instruction queue has room; an
// instruction keeps its queue entry until its last byte moves to the output
// register, so full rises when the queue holds four instructions, the one
// being streamed included. requests with an unused selector (48 to 63) get no
// queue entry, also while full is high, and produce no words. there is no
// configuration and no state carried from one instruction to the next.
// ----------------------------------------------------------------------------
module x86_instruction_byte_encoder
    import xie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    // request side
    input  logic     push,
    output logic     full,
    input  xie_in_t  instr,
    // byte side
    output logic     empty,
    input  logic     pop,
    output xie_out_t code
);

    xie_plan_t plan;
    xie_head_t head;
    logic      take;
    logic      q_wr;

    // front end: full byte sequence and length of the request
    xie_front u_front (
        .instr (instr),
        .plan  (plan)
    );

    // empty encodings are dropped here, so the back end only sees real bytes
    assign q_wr = push && (plan.len != '0);

    xie_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_plan (plan),
        .full    (full),
        .rd_en   (take),
        .head    (head)
    );

    // back end: walks the head instruction byte by byte
    xie_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .take  (take),
        .empty (empty),
        .pop   (pop),
        .code  (code)
    );

endmodule
